[src/lcar_pkg.sv]
// Shared types and constants of the load cell converter reader.
`default_nettype none

package lcar_pkg;

  // Default converter word width, average width and register port width.
  localparam int unsigned DEF_DATA_BITS = 24;
  localparam int unsigned AVG_W         = 24;
  localparam int unsigned ADDR_W        = 4;
  localparam int unsigned PDATA_W       = 32;

  // Register reset values.
  localparam logic [1:0]  RST_GAIN_PULSES = 2'd1;
  localparam logic [7:0]  RST_SAMPLE_CNT  = 8'd10;
  localparam logic [23:0] RST_TIMEOUT     = 24'd600000;

  // A sample count of zero stands for this many conversions.
  localparam logic [7:0]  ZERO_COUNT_SAMPLES = 8'd10;

  // Saturation limits of the signed average.
  localparam logic [AVG_W-1:0] AVG_MIN_MAG = 24'h800000;
  localparam logic [AVG_W-1:0] AVG_MAX_POS = 24'h7FFFFF;

  typedef enum logic [1:0] {
    REG_GAIN_PULSES = 2'd0,
    REG_SAMPLE_CNT  = 2'd1,
    REG_TIMEOUT     = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_BIT_HIGH,
    PH_BIT_LOW,
    PH_GAIN_HIGH,
    PH_GAIN_LOW
  } phase_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_PREP,
    SQ_DIV,
    SQ_DONE
  } seq_e;

endpackage

`default_nettype wire

[src/lcar_in_if.sv]
// Input channel of the load cell converter reader: one timing tick per item.
`default_nettype none

interface lcar_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic data_line;

  modport source (output valid, output start_req, output data_line, input ready);
  modport sink   (input valid, input start_req, input data_line, output ready);
endinterface

`default_nettype wire

[src/lcar_out_if.sv]
// Result channel of the load cell converter reader: one result per tick.
`default_nettype none

interface lcar_out_if;
  logic                               valid;
  logic                               ready;
  logic                               clock_line;
  logic                               busy_res;
  logic                               done_res;
  logic                               timed_out;
  logic signed [lcar_pkg::AVG_W-1:0]  average;

  modport source (output valid, output clock_line, output busy_res, output done_res,
                  output timed_out, output average, input ready);
  modport sink   (input valid, input clock_line, input busy_res, input done_res,
                  input timed_out, input average, output ready);
endinterface

`default_nettype wire

[src/load_cell_adc_reader_unit.sv]
// Top level of the load cell converter reader: bit-bang sequencer and averaging divider.
`default_nettype none

// Each input item is one timing tick of the converter's serial interface; each tick
// yields exactly one result item that carries the clock pin level, the busy flag and
// the done or timeout flags. A start request in idle begins a reading: when the gain
// pulse setting differs from the one used last, one conversion is run and thrown
// away first, then the configured number of conversions (zero means ten) are read,
// each after the data line goes low, as DATA_BITS bits MSB first followed by the gain
// pulses. The words are sign-extended and summed. Almost every tick has its result
// registered as it is taken, and a new tick is taken as soon as the result register
// is free. The tick that completes a reading is the exception: the rounded mean is
// computed by a restoring divider that produces one quotient bit per cycle, and no
// tick is taken while it runs. That tick's result appears after these steps: taking
// the tick, forming the rounded dividend, DATA_BITS + 8 divider steps, and saturating
// and registering the result. The timeout register is read live; gain pulses and
// sample count are latched at the start of a reading. Registers sit at byte addresses
// 0, 4 and 8 of the APB-style port and should be written only while no reading is in
// progress.
module load_cell_adc_reader_unit #(
  parameter int unsigned DATA_BITS = lcar_pkg::DEF_DATA_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lcar_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [lcar_pkg::PDATA_W-1:0]  pwdata,
  output logic      [lcar_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  lcar_in_if.sink                            in_if,
  lcar_out_if.source                         out_if
);
  import lcar_pkg::*;

  // The sum must hold 255 words of DATA_BITS bits, so it is eight bits wider.
  localparam int unsigned SUM_W  = DATA_BITS + 8;
  localparam int unsigned BIT_CW = $clog2(DATA_BITS + 1);
  localparam int unsigned DIV_CW = $clog2(SUM_W);
  localparam int unsigned QX_W   = (SUM_W > AVG_W) ? SUM_W : AVG_W + 1;

  // Configuration registers.
  logic [1:0]  gain_q;
  logic [7:0]  scount_q;
  logic [23:0] tmo_q;
  reg_idx_e    reg_idx;
  logic        cfg_wr;

  // Tick state.
  phase_e              phase_q, phase_d;
  logic [BIT_CW-1:0]   bit_q, bit_d;
  logic [DATA_BITS-1:0] shift_q, shift_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [7:0]          left_q, left_d;
  logic [7:0]          total_q, total_d;
  logic [23:0]         wait_q, wait_d;
  logic [1:0]          last_gain_q, last_gain_d;
  logic [1:0]          pulse_q, pulse_d;
  logic                discard_q, discard_d;

  // Per-tick flags.
  logic                tick_clk, tick_tout, conv_end, fin;
  logic [BIT_CW-1:0]   bit_inc;
  logic [23:0]         wait_inc;
  logic [1:0]          pulse_inc;
  logic [7:0]          left_dec;
  logic [7:0]          start_total;

  // Divider sequencer.
  seq_e                seq_q, seq_d;
  logic [SUM_W-1:0]    div_q, div_d;
  logic [8:0]          rem_q, rem_d;
  logic [DIV_CW-1:0]   cnt_q, cnt_d;
  logic                neg_q, neg_d;
  logic [8:0]          rem_sh;
  logic                q_bit;
  logic [SUM_W-1:0]    half;
  logic [QX_W-1:0]     q_x;
  logic [AVG_W-1:0]    q_sat;
  logic [AVG_W-1:0]    avg_fin;

  // Result register.
  logic                out_valid_q;
  logic                o_clk_q, o_busy_q, o_done_q, o_tout_q;
  logic [AVG_W-1:0]    o_avg_q;

  logic                accept;
  logic                load_tick;
  logic                load_fin;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    unique case (reg_idx)
      REG_GAIN_PULSES: prdata = PDATA_W'(gain_q);
      REG_SAMPLE_CNT:  prdata = PDATA_W'(scount_q);
      REG_TIMEOUT:     prdata = PDATA_W'(tmo_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= RST_GAIN_PULSES;
      scount_q <= RST_SAMPLE_CNT;
      tmo_q    <= RST_TIMEOUT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GAIN_PULSES: gain_q   <= pwdata[1:0];
        REG_SAMPLE_CNT:  scount_q <= pwdata[7:0];
        REG_TIMEOUT:     tmo_q    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- tick datapath
  assign bit_inc     = bit_q + 1'b1;
  assign wait_inc    = wait_q + 24'd1;
  assign pulse_inc   = pulse_q + 2'd1;
  assign left_dec    = left_q - 8'd1;
  assign start_total = (scount_q == 8'd0) ? ZERO_COUNT_SAMPLES : scount_q;

  always_comb begin
    bit_d       = bit_q;
    shift_d     = shift_q;
    sum_d       = sum_q;
    left_d      = left_q;
    total_d     = total_q;
    wait_d      = wait_q;
    last_gain_d = last_gain_q;
    pulse_d     = pulse_q;
    discard_d   = discard_q;
    tick_clk    = 1'b0;
    tick_tout   = 1'b0;
    conv_end    = 1'b0;
    fin         = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (in_if.start_req) begin
          discard_d   = (gain_q != last_gain_q);
          last_gain_d = gain_q;
          total_d     = start_total;
          left_d      = start_total;
          sum_d       = '0;
          wait_d      = '0;
        end
      end
      PH_WAIT: begin
        if (!in_if.data_line) begin
          bit_d   = '0;
          shift_d = '0;
        end else begin
          wait_d    = wait_inc;
          tick_tout = (wait_inc >= tmo_q);
        end
      end
      PH_BIT_HIGH: tick_clk = 1'b1;
      PH_BIT_LOW: begin
        shift_d = {shift_q[DATA_BITS-2:0], in_if.data_line};
        bit_d   = bit_inc;
        if (bit_inc >= BIT_CW'(DATA_BITS)) begin
          pulse_d  = '0;
          conv_end = (last_gain_q == 2'd0);
        end
      end
      PH_GAIN_HIGH: tick_clk = 1'b1;
      PH_GAIN_LOW: begin
        pulse_d  = pulse_inc;
        conv_end = (pulse_inc == last_gain_q);
      end
      default: ;
    endcase

    if (conv_end) begin
      wait_d = '0;
      if (discard_q) begin
        discard_d = 1'b0;
      end else begin
        sum_d  = sum_q + {{8{shift_d[DATA_BITS-1]}}, shift_d};
        left_d = left_dec;
        fin    = (left_dec == 8'd0);
      end
    end
  end

  // Next phase of the serial interface.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE:      if (in_if.start_req) phase_d = PH_WAIT;
      PH_WAIT: begin
        if (!in_if.data_line) phase_d = PH_BIT_HIGH;
        else if (tick_tout)   phase_d = PH_IDLE;
      end
      PH_BIT_HIGH:  phase_d = PH_BIT_LOW;
      PH_BIT_LOW:   phase_d = (bit_inc >= BIT_CW'(DATA_BITS)) ? PH_GAIN_HIGH : PH_BIT_HIGH;
      PH_GAIN_HIGH: phase_d = PH_GAIN_LOW;
      PH_GAIN_LOW:  phase_d = PH_GAIN_HIGH;
      default:      phase_d = PH_IDLE;
    endcase
    if (conv_end) begin
      phase_d = fin ? PH_IDLE : PH_WAIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_q       <= '0;
      shift_q     <= '0;
      sum_q       <= '0;
      left_q      <= '0;
      total_q     <= '0;
      wait_q      <= '0;
      last_gain_q <= RST_GAIN_PULSES;
      pulse_q     <= '0;
      discard_q   <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      sum_q       <= sum_d;
      left_q      <= left_d;
      total_q     <= total_d;
      wait_q      <= wait_d;
      last_gain_q <= last_gain_d;
      pulse_q     <= pulse_d;
      discard_q   <= discard_d;
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign accept = in_if.valid & in_if.ready;

  // Next sequencer state.
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SQ_IDLE: if (accept && fin) seq_d = SQ_PREP;
      SQ_PREP: seq_d = SQ_DIV;
      SQ_DIV:  if (cnt_q == DIV_CW'(SUM_W - 1)) seq_d = SQ_DONE;
      SQ_DONE: seq_d = SQ_IDLE;
      default: seq_d = SQ_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_if.ready = 1'b0;
    load_tick   = 1'b0;
    load_fin    = 1'b0;
    unique case (seq_q)
      SQ_IDLE: begin
        in_if.ready = !out_valid_q || out_if.ready;
        load_tick   = accept && !fin;
      end
      SQ_DONE: load_fin = 1'b1;
      default: ;
    endcase
  end

  // Restoring division of the rounded magnitude by the sample total.
  assign half   = SUM_W'(total_q[7:1]);
  assign rem_sh = {rem_q[7:0], div_q[SUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, total_q});

  always_comb begin
    div_d = div_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    unique case (seq_q)
      SQ_PREP: begin
        neg_d = sum_q[SUM_W-1];
        div_d = sum_q[SUM_W-1] ? (~sum_q + half + SUM_W'(1)) : (sum_q + half);
        rem_d = '0;
        cnt_d = '0;
      end
      SQ_DIV: begin
        rem_d = q_bit ? (rem_sh - {1'b0, total_q}) : rem_sh;
        div_d = {div_q[SUM_W-2:0], q_bit};
        cnt_d = cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign q_x     = QX_W'(div_q);
  assign q_sat   = (q_x > QX_W'(AVG_MIN_MAG)) ? AVG_MIN_MAG : q_x[AVG_W-1:0];
  assign avg_fin = neg_q ? (AVG_W'(0) - q_sat)
                         : ((q_sat == AVG_MIN_MAG) ? AVG_MAX_POS : q_sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SQ_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      seq_q <= seq_d;
      if (load_tick || load_fin) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    if (load_tick) begin
      o_clk_q  <= tick_clk;
      o_busy_q <= (phase_d != PH_IDLE);
      o_done_q <= 1'b0;
      o_tout_q <= tick_tout;
      o_avg_q  <= '0;
    end else if (load_fin) begin
      o_clk_q  <= 1'b0;
      o_busy_q <= 1'b0;
      o_done_q <= 1'b1;
      o_tout_q <= 1'b0;
      o_avg_q  <= avg_fin;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.clock_line = o_clk_q;
  assign out_if.busy_res   = o_busy_q;
  assign out_if.done_res   = o_done_q;
  assign out_if.timed_out  = o_tout_q;
  assign out_if.average    = o_avg_q;

  // ---------------------------------------------------------------- assertions
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> (seq_q == SQ_IDLE))
    else $error("input taken while the divider is running");

  a_prep_then_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_PREP) |=> (seq_q == SQ_DIV))
    else $error("divider preparation not followed by division");

  a_fin_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_DONE) |-> !out_valid_q)
    else $error("final result would overwrite a pending result");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.done_res) |-> (!out_if.busy_res && !out_if.timed_out))
    else $error("done result flagged busy or timed out");

  a_avg_zero_else: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.done_res) |-> (out_if.average == '0))
    else $error("average nonzero outside a done result");

endmodule

`default_nettype wire
